@@ src/assert_macros.svh @@
// Assertion macros used by the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define KOP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion on the block clock and reset.
`define KOP_ASSERT(label, prop, msg) `KOP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

@@ src/kop_pkg.sv @@
`timescale 1ns / 1ps

package kop_pkg;

    // Fixed-point constants: reals are signed Q.30, angles are 32-bit turn phases.
    localparam int KOP_CORDIC_STAGES = 16;
    localparam int KOP_TABLE_LEN     = 24;
    localparam int KOP_CW            = 33;
    localparam int KOP_ZW            = 34;
    localparam int KOP_GAIN_START    = 652032874;
    localparam int KOP_RAD_TO_PHASE  = 683565276;
    localparam int KOP_DSPLIT        = 17;
    localparam int KOP_PACK_W        = 66;
    localparam int KOP_IDX_W         = 2;

    localparam logic signed [63:0] KOP_QONE    = 64'sd1073741824;
    localparam logic signed [63:0] KOP_QONE_SQ = 64'sh1000_0000_0000_0000;

    // Configuration register indexes.
    localparam logic [KOP_IDX_W-1:0] KOP_REG_ECC    = 2'd0;
    localparam logic [KOP_IDX_W-1:0] KOP_REG_AXIS   = 2'd1;
    localparam logic [KOP_IDX_W-1:0] KOP_REG_PERIOD = 2'd2;

    // Arctangent of 2^-i as a turn phase.
    function automatic logic [31:0] kop_atan(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Denominator 1 + x from the raw Q.60 product x, forced to one when not positive.
    function automatic logic [31:0] kop_den(input logic signed [63:0] prod);
        logic signed [63:0] d;
        d = KOP_QONE + (prod >>> 30);
        if (d <= 64'sd0) begin
            d = KOP_QONE;
        end
        return d[31:0];
    endfunction

    // Saturation of an output coordinate to 33 signed bits.
    function automatic logic [KOP_CW-1:0] kop_pack(input logic signed [KOP_PACK_W-1:0] v);
        logic [KOP_CW-1:0] r;
        if (v > 66'sd4294967295) begin
            r = 33'h0_FFFF_FFFF;
        end else if (v < -66'sd4294967296) begin
            r = 33'h1_0000_0000;
        end else begin
            r = v[KOP_CW-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/kop_delay.sv @@
`timescale 1ns / 1ps

module kop_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [DEPTH];

    // Shift line that moves with the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

@@ src/kop_div.sv @@
`timescale 1ns / 1ps

module kop_div #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [N_W-1:0] o_quo
);

    // One quotient bit per stage: the numerator shifts out as quotient bits shift in.
    logic [D_W-1:0] r_rem [N_W-1];
    logic [D_W-1:0] r_den [N_W-1];
    logic [N_W-1:0] r_nq  [N_W];

    for (genvar k = 0; k < N_W; k++) begin : g_stage
        logic [D_W-1:0] rem_in;
        logic [D_W-1:0] den_in;
        logic [N_W-1:0] nq_in;
        logic [D_W:0]   trial;
        logic [D_W:0]   diff;
        logic           q_bit;
        logic [D_W-1:0] n_rem;
        logic [N_W-1:0] n_nq;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = i_den;
            assign nq_in  = i_num;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign nq_in  = r_nq[k-1];
        end

        // Restoring step: subtract the divisor when it fits.
        always_comb begin
            trial = {rem_in, nq_in[N_W-1]};
            diff  = trial - {1'b0, den_in};
            q_bit = (trial >= {1'b0, den_in});
            n_rem = q_bit ? diff[D_W-1:0] : trial[D_W-1:0];
            n_nq  = {nq_in[N_W-2:0], q_bit};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k] <= n_nq;
            end
        end

        if (k < N_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_nq[N_W-1];

endmodule

@@ src/kop_isqrt.sv @@
`timescale 1ns / 1ps

module kop_isqrt #(
    parameter int RW = 31
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_val,
    output logic [RW-1:0]   o_root
);

    // One root bit per stage, two radicand bits consumed per stage.
    logic [RW+1:0]   r_rem  [RW-1];
    logic [2*RW-1:0] r_v    [RW-1];
    logic [RW-1:0]   r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [2*RW-1:0] v_in;
        logic [RW-1:0]   root_in;
        logic [RW+3:0]   cur;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            fits;
        logic [RW+1:0]   n_rem;
        logic [RW-1:0]   n_root;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign v_in    = i_val;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign v_in    = r_v[k-1];
            assign root_in = r_root[k-1];
        end

        // Try 4*root + 1 against the remainder with the next two bits appended.
        always_comb begin
            cur    = {rem_in, v_in[2*RW-1 -: 2]};
            trial  = {2'b00, root_in, 2'b01};
            diff   = cur - trial;
            fits   = (cur >= trial);
            n_rem  = fits ? diff[RW+1:0] : cur[RW+1:0];
            n_root = {root_in[RW-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
            end
        end

        if (k < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_v[k]   <= {v_in[2*RW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

@@ src/kop_cordic.sv @@
`timescale 1ns / 1ps

module kop_cordic import kop_pkg::*; #(
    parameter int STG = KOP_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [31:0]              i_phase,
    output logic signed [KOP_CW-1:0] o_cos,
    output logic signed [KOP_CW-1:0] o_sin
);

    localparam logic signed [KOP_ZW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [KOP_ZW-1:0] HALF    = 34'sd2147483648;

    logic signed [KOP_ZW-1:0] r_fz;
    logic                     r_fflip;
    logic signed [KOP_CW-1:0] r_x    [STG];
    logic signed [KOP_CW-1:0] r_y    [STG];
    logic signed [KOP_ZW-1:0] r_z    [STG-1];
    logic                     r_flip [STG];
    logic signed [KOP_CW-1:0] r_cos;
    logic signed [KOP_CW-1:0] r_sin;

    logic signed [KOP_ZW-1:0] z0;
    logic signed [KOP_ZW-1:0] n_fz;
    logic                     n_fflip;

    // Fold the angle into a quarter turn either side of zero.
    always_comb begin
        z0      = KOP_ZW'($signed(i_phase));
        n_fz    = z0;
        n_fflip = 1'b0;
        if (z0 > QUARTER) begin
            n_fz    = z0 - HALF;
            n_fflip = 1'b1;
        end else if (z0 < -QUARTER) begin
            n_fz    = z0 + HALF;
            n_fflip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fz    <= n_fz;
            r_fflip <= n_fflip;
        end
    end

    // Rotation stages, one micro-rotation each.
    for (genvar k = 0; k < STG; k++) begin : g_iter
        logic signed [KOP_CW-1:0] x_in;
        logic signed [KOP_CW-1:0] y_in;
        logic signed [KOP_ZW-1:0] z_in;
        logic                     f_in;
        logic signed [KOP_ZW-1:0] ang;
        logic signed [KOP_CW-1:0] n_x;
        logic signed [KOP_CW-1:0] n_y;
        logic signed [KOP_ZW-1:0] n_z;

        if (k == 0) begin : g_first
            assign x_in = KOP_CW'(KOP_GAIN_START);
            assign y_in = '0;
            assign z_in = r_fz;
            assign f_in = r_fflip;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign f_in = r_flip[k-1];
        end

        always_comb begin
            ang = $signed({2'b00, kop_atan(k)});
            if (z_in >= 0) begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - ang;
            end else begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_flip[k] <= f_in;
            end
        end

        if (k < STG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[k] <= n_z;
                end
            end
        end
    end

    // Undo the half-turn fold.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[STG-1] ? -r_x[STG-1] : r_x[STG-1];
            r_sin <= r_flip[STG-1] ? -r_y[STG-1] : r_y[STG-1];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ src/kepler_orbit_position.sv @@
`timescale 1ns / 1ps

// Orbit position from time. Each accepted time sample gives one (x, y) result, and a new
// sample can be taken in every cycle while o_in_stall is low. The number of CORDIC stages
// is capped at 24, with a default of 16. Most of the depth comes from the
// one-bit-per-stage pipelines: 64 stages for the mean-anomaly division, two CORDIC
// rotators in series, and 61 stages each for the cosine-ratio and distance divisions, with
// the 31-stage square root running beside the last. The whole pipeline advances together;
// it holds only while a result waits in the output register and another is ready behind
// it, so input transfers continue while the final stage is empty. Configuration is taken
// on every cycle; the coefficients derived from a write are registered behind it.

module kepler_orbit_position import kop_pkg::*; #(
    parameter int CORDIC_STAGES = KOP_CORDIC_STAGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_time_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KOP_CW-1:0]    o_pos_x,
    output logic [KOP_CW-1:0]    o_pos_y,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [KOP_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    `include "assert_macros.svh"

    localparam int STG    = (CORDIC_STAGES < KOP_TABLE_LEN) ? CORDIC_STAGES : KOP_TABLE_LEN;
    localparam int LC     = STG + 2;
    localparam int DIVM_N = 64;
    localparam int DIVR_N = 61;
    localparam int DIVD_N = 61;
    localparam int ISQ_RW = 31;
    localparam int LAT    = DIVM_N + 1 + LC + 4 + LC + 2 + DIVR_N + 3 + DIVD_N + 1;
    localparam int D_M    = LC + 3;
    localparam int D_SGN  = LC + 2 + DIVR_N + 3 + DIVD_N;
    localparam int D_E0   = LC + 4 + DIVR_N + 3 + DIVD_N;
    localparam int CNT_W  = $clog2(LAT + 2) + 1;

    // Configuration registers and the values derived from them.
    logic [15:0] r_ecc;
    logic [30:0] r_axis;
    logic [31:0] r_period;
    logic [29:0] r_e2;
    logic [29:0] r_e3;
    logic [30:0] r_k1;
    logic [30:0] r_k2;
    logic [30:0] r_k3;
    logic [60:0] r_num2;
    logic [30:0] e_q;
    logic [31:0] e2_full;
    logic [45:0] e3_full;
    logic [31:0] e3x3;
    logic [61:0] num2_full;

    assign o_cfg_ready = 1'b1;
    assign e_q         = {1'b0, r_ecc, 14'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecc    <= '0;
            r_axis   <= 31'd65536;
            r_period <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                KOP_REG_ECC:    r_ecc    <= i_cfg_data[15:0];
                KOP_REG_AXIS:   r_axis   <= i_cfg_data[30:0];
                KOP_REG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // e squared and cubed in Q.30, then the series coefficients and a(1 - e^2).
    always_comb begin
        e2_full   = r_ecc * r_ecc;
        e3_full   = r_e2 * r_ecc;
        e3x3      = 32'(r_e3) * 32'd3;
        num2_full = r_axis * (31'(KOP_QONE) - {1'b0, r_e2});
    end

    always_ff @(posedge i_clk) begin
        r_e2   <= e2_full[31:2];
        r_e3   <= e3_full[45:16];
        r_k1   <= e_q - {4'b0, r_e3[29:3]};
        r_k2   <= {2'b0, r_e2[29:1]};
        r_k3   <= {2'b0, e3x3[31:3]};
        r_num2 <= num2_full[60:0];
    end

    // Pipeline enable and valid line.
    logic           en;
    logic [LAT-1:0] r_vld;
    logic           r_out_valid;
    logic [KOP_CW-1:0] r_out_x;
    logic [KOP_CW-1:0] r_out_y;

    assign en         = !(r_vld[LAT-1] && r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Mean anomaly: low quotient bits of (t * 2^32) / period.
    logic [DIVM_N-1:0] quo_m;
    logic [31:0]       m_w;
    logic [31:0]       r_a_m;
    logic [31:0]       r_a_m2;
    logic [31:0]       r_a_m3;

    kop_div #(.N_W(DIVM_N), .D_W(32)) u_div_m (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({i_time_value, 32'b0}),
        .i_den (r_period),
        .o_quo (quo_m)
    );

    assign m_w = (r_period != 32'd0) ? quo_m[31:0] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_m  <= m_w;
            r_a_m2 <= {m_w[30:0], 1'b0};
            r_a_m3 <= m_w + {m_w[30:0], 1'b0};
        end
    end

    // Sines of M, 2M and 3M, and the cosine of M for the circular case.
    logic signed [KOP_CW-1:0] c1;
    logic signed [KOP_CW-1:0] s1;
    logic signed [KOP_CW-1:0] s2;
    logic signed [KOP_CW-1:0] s3;

    kop_cordic #(.STG(STG)) u_cordic_m1 (
        .i_clk (i_clk), .i_en (en), .i_phase (r_a_m), .o_cos (c1), .o_sin (s1)
    );
    kop_cordic #(.STG(STG)) u_cordic_m2 (
        .i_clk (i_clk), .i_en (en), .i_phase (r_a_m2), .o_cos (), .o_sin (s2)
    );
    kop_cordic #(.STG(STG)) u_cordic_m3 (
        .i_clk (i_clk), .i_en (en), .i_phase (r_a_m3), .o_cos (), .o_sin (s3)
    );

    logic [31:0] m_del;

    kop_delay #(.W(32), .DEPTH(D_M)) u_dly_m (
        .i_clk (i_clk), .i_en (en), .i_d (r_a_m), .o_q (m_del)
    );

    // Series terms, their sum, and conversion from radians to phase.
    logic signed [63:0] r_b_p1;
    logic signed [63:0] r_b_p2;
    logic signed [63:0] r_b_p3;
    logic signed [63:0] r_b_ax;
    logic signed [63:0] r_b_ay;
    logic signed [63:0] sum_w;
    logic signed [33:0] r_c_sum;
    logic [KOP_CW-1:0]  r_c_ex;
    logic [KOP_CW-1:0]  r_c_ey;
    logic signed [63:0] r_d_prod;
    logic signed [63:0] pd_sh;
    logic [31:0]        r_e_ep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_p1 <= s1 * $signed({1'b0, r_k1});
            r_b_p2 <= s2 * $signed({1'b0, r_k2});
            r_b_p3 <= s3 * $signed({1'b0, r_k3});
            r_b_ax <= $signed({1'b0, r_axis}) * c1;
            r_b_ay <= $signed({1'b0, r_axis}) * s1;
        end
    end

    assign sum_w = (r_b_p1 >>> 30) + (r_b_p2 >>> 30) + (r_b_p3 >>> 30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sum <= sum_w[33:0];
            r_c_ex  <= kop_pack(KOP_PACK_W'(r_b_ax >>> 30));
            r_c_ey  <= kop_pack(KOP_PACK_W'(r_b_ay >>> 30));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_prod <= r_c_sum * $signed(31'(KOP_RAD_TO_PHASE));
        end
    end

    assign pd_sh = r_d_prod >>> 30;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_ep <= m_del + pd_sh[31:0];
        end
    end

    // Cosine of the eccentric anomaly.
    logic signed [KOP_CW-1:0] c4;

    kop_cordic #(.STG(STG)) u_cordic_e (
        .i_clk (i_clk), .i_en (en), .i_phase (r_e_ep), .o_cos (c4), .o_sin ()
    );

    // Ratio (e + cos E) / (1 + e cos E), divided as a magnitude.
    logic signed [63:0] r_f_ec;
    logic signed [33:0] r_f_sum;
    logic signed [33:0] mag_w;
    logic [31:0]        r_g_den;
    logic [DIVR_N-1:0]  r_g_num;
    logic               r_g_neg;
    logic [DIVR_N-1:0]  quo_r;
    logic               neg_del;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_ec  <= $signed({1'b0, e_q}) * c4;
            r_f_sum <= 34'($signed({1'b0, e_q})) + 34'(c4);
        end
    end

    assign mag_w = (r_f_sum < 0) ? -r_f_sum : r_f_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_den <= kop_den(r_f_ec);
            r_g_num <= {mag_w[30:0], 30'b0};
            r_g_neg <= (r_f_sum < 0);
        end
    end

    kop_div #(.N_W(DIVR_N), .D_W(32)) u_div_r (
        .i_clk (i_clk), .i_en (en), .i_num (r_g_num), .i_den (r_g_den), .o_quo (quo_r)
    );

    kop_delay #(.W(1), .DEPTH(DIVR_N)) u_dly_neg (
        .i_clk (i_clk), .i_en (en), .i_d (r_g_neg), .o_q (neg_del)
    );

    // Clamp the ratio magnitude to one, restore its sign.
    logic [30:0]        rmag_w;
    logic signed [31:0] r_h_r;
    logic signed [63:0] r_i_r2;
    logic signed [63:0] r_i_er;
    logic signed [31:0] r_i_r;
    logic signed [63:0] v_w;
    logic [61:0]        r_j_v;
    logic [31:0]        r_j_den;
    logic signed [31:0] r_j_r;

    assign rmag_w = (quo_r > DIVR_N'(KOP_QONE)) ? 31'(KOP_QONE) : quo_r[30:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_r <= neg_del ? -$signed({1'b0, rmag_w}) : $signed({1'b0, rmag_w});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_r2 <= r_h_r * r_h_r;
            r_i_er <= $signed({1'b0, e_q}) * r_h_r;
            r_i_r  <= r_h_r;
        end
    end

    assign v_w = KOP_QONE_SQ - r_i_r2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_v   <= v_w[61:0];
            r_j_den <= kop_den(r_i_er);
            r_j_r   <= r_i_r;
        end
    end

    // Sine magnitude by square root; distance by division.
    logic [ISQ_RW-1:0]  root_w;
    logic [ISQ_RW-1:0]  root_del;
    logic [DIVD_N-1:0]  quo_d;
    logic signed [31:0] r_del;
    logic               sgn_del;

    kop_isqrt #(.RW(ISQ_RW)) u_isqrt (
        .i_clk (i_clk), .i_en (en), .i_val (r_j_v), .o_root (root_w)
    );

    kop_delay #(.W(ISQ_RW), .DEPTH(DIVD_N - ISQ_RW)) u_dly_root (
        .i_clk (i_clk), .i_en (en), .i_d (root_w), .o_q (root_del)
    );

    kop_div #(.N_W(DIVD_N), .D_W(32)) u_div_d (
        .i_clk (i_clk), .i_en (en), .i_num (r_num2), .i_den (r_j_den), .o_quo (quo_d)
    );

    kop_delay #(.W(32), .DEPTH(DIVD_N)) u_dly_r (
        .i_clk (i_clk), .i_en (en), .i_d (r_j_r), .o_q (r_del)
    );

    kop_delay #(.W(1), .DEPTH(D_SGN)) u_dly_sgn (
        .i_clk (i_clk), .i_en (en), .i_d (r_e_ep[31]), .o_q (sgn_del)
    );

    // Circular-orbit result rides alongside.
    logic [KOP_CW-1:0] ex_del;
    logic [KOP_CW-1:0] ey_del;

    kop_delay #(.W(2 * KOP_CW), .DEPTH(D_E0)) u_dly_e0 (
        .i_clk (i_clk), .i_en (en), .i_d ({r_c_ex, r_c_ey}), .o_q ({ex_del, ey_del})
    );

    // Distance times cosine and sine, as two partial products each.
    logic [33:0]        d_w;
    logic signed [31:0] sn_w;
    logic signed [49:0] r_k_xl;
    logic signed [49:0] r_k_xh;
    logic signed [49:0] r_k_yl;
    logic signed [49:0] r_k_yh;
    logic [KOP_CW-1:0]  r_k_ex;
    logic [KOP_CW-1:0]  r_k_ey;

    assign d_w  = quo_d[33:0];
    assign sn_w = sgn_del ? -$signed({1'b0, root_del}) : $signed({1'b0, root_del});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_xl <= $signed({1'b0, d_w[KOP_DSPLIT-1:0]}) * r_del;
            r_k_xh <= $signed({1'b0, d_w[33:KOP_DSPLIT]}) * r_del;
            r_k_yl <= $signed({1'b0, d_w[KOP_DSPLIT-1:0]}) * sn_w;
            r_k_yh <= $signed({1'b0, d_w[33:KOP_DSPLIT]}) * sn_w;
            r_k_ex <= ex_del;
            r_k_ey <= ey_del;
        end
    end

    // Combine, scale, saturate and pick the circular result when e is zero.
    logic signed [KOP_PACK_W-1:0] px_w;
    logic signed [KOP_PACK_W-1:0] py_w;

    assign px_w = (KOP_PACK_W'(r_k_xh) <<< KOP_DSPLIT) + KOP_PACK_W'(r_k_xl);
    assign py_w = (KOP_PACK_W'(r_k_yh) <<< KOP_DSPLIT) + KOP_PACK_W'(r_k_yl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_vld[LAT-1]) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[LAT-1]) begin
            r_out_x <= (r_ecc == 16'd0) ? r_k_ex : kop_pack(px_w >>> 30);
            r_out_y <= (r_ecc == 16'd0) ? r_k_ey : kop_pack(py_w >>> 30);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;

    // Count of items accepted and not yet delivered, for checking.
    logic [CNT_W-1:0] r_inflight;
    logic             acc_in;
    logic             acc_out;

    assign acc_in  = i_in_valid && en;
    assign acc_out = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (acc_in && !acc_out) begin
            r_inflight <= r_inflight + CNT_W'(1);
        end else if (!acc_in && acc_out) begin
            r_inflight <= r_inflight - CNT_W'(1);
        end
    end

    `KOP_ASSERT(a_hold_frozen, !en |=> $stable(r_vld), "pipeline moved while a result was held")
    `KOP_ASSERT(a_inflight, r_inflight == ($countones(r_vld) + r_out_valid), "items lost")
    `KOP_ASSERT(a_out_source, $rose(r_out_valid) |-> $past(r_vld[LAT-1]), "result without item")

endmodule
